// ===== hdl/bblru_pkg.sv =====
package bblru_pkg;

  // Default geometry
  localparam int unsigned EntriesDef     = 32;
  localparam int unsigned KeyBitsDef     = 64;
  localparam int unsigned PayloadBitsDef = 32;

  // Fixed port widths
  localparam int unsigned KeyPortW    = 64;
  localparam int unsigned DataPortW   = 32;
  localparam int unsigned ChargeW     = 32;
  localparam int unsigned KindW       = 3;

  localparam logic [31:0] BudgetReset = 32'd1048576;

  // Result kinds
  localparam logic [KindW-1:0] KindHit        = 3'd0;
  localparam logic [KindW-1:0] KindMiss       = 3'd1;
  localparam logic [KindW-1:0] KindEvicted    = 3'd2;
  localparam logic [KindW-1:0] KindStored     = 3'd3;
  localparam logic [KindW-1:0] KindRefBig     = 3'd4;
  localparam logic [KindW-1:0] KindRefPresent = 3'd5;

  // Request opcodes
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

endpackage

// ===== hdl/byte_budget_lru_cache.sv =====
// Byte-budget LRU cache. Entry keys, payloads and charges sit in one RAM with
// a registered read port; valid bits, recency ranks, the entry count and the
// byte, hit and miss totals are flip-flops. One request is handled at a time.
// A get or a put scans the RAM at one slot per cycle and stops early when the
// key is found; a put that is refused for size skips the scan. Each eviction
// passes a fit check, a RAM read of the oldest slot, then the result; storing
// the new entry passes a fit check, then the store. Stalls on the result side
// hold these steps. A new request is taken as soon as the final result has
// been loaded into the output register. The budget register may be written
// at any time through the configuration channel; write it only while idle.
module byte_budget_lru_cache
  import bblru_pkg::*;
#(
  parameter int unsigned ENTRIES      = EntriesDef,
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_data_i,
  // Request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [KeyPortW-1:0]  key_i,
  input  logic [DataPortW-1:0] payload_i,
  input  logic [ChargeW-1:0]   charge_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [KindW-1:0]     kind_o,
  output logic [KeyPortW-1:0]  key_out_o,
  output logic [DataPortW-1:0] payload_out_o,
  output logic [31:0]          used_bytes_o,
  output logic [31:0]          hit_count_o,
  output logic [31:0]          miss_count_o,
  output logic                 last_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned KW = KEY_BITS;
  localparam int unsigned PW = PAYLOAD_BITS;
  localparam int unsigned MW = ChargeW + PW + KW;

  typedef enum logic [5:0] {
    StIdle    = 6'b000001,
    StSearch  = 6'b000010,
    StResolve = 6'b000100,
    StCheck   = 6'b001000,
    StEvict   = 6'b010000,
    StStore   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Request registers
  logic               op_q;
  logic [KW-1:0]      key_q;
  logic [PW-1:0]      pay_q;
  logic [ChargeW-1:0] charge_q;

  // Cache state in flops
  logic [31:0]        budget_q;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [IW-1:0]      rank_d [ENTRIES];
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [31:0]        used_q, used_d;
  logic [31:0]        hits_q, hits_d;
  logic [31:0]        miss_q, miss_d;

  // Scan control
  logic [IW-1:0]      addr_q, addr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic               found_q, found_d;
  logic [IW-1:0]      slot_q, slot_d;
  logic [PW-1:0]      hit_pay_q, hit_pay_d;
  logic               ev_rdy_q, ev_rdy_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [KindW-1:0]   kind_q, kind_d;
  logic [KeyPortW-1:0] okey_q, okey_d;
  logic [DataPortW-1:0] opay_q, opay_d;
  logic               last_q, last_d;
  logic               out_free;

  // RAM port
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [MW-1:0]      ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [MW-1:0]      ram_rdata;
  logic [KW-1:0]      rd_key;
  logic [PW-1:0]      rd_pay;
  logic [ChargeW-1:0] rd_charge;

  // Helpers
  logic               in_acc;
  logic [KW-1:0]      key_in;
  logic [PW-1:0]      pay_in;
  logic               over;
  logic [IW-1:0]      oldest;
  logic [IW-1:0]      free_slot;
  logic [IW-1:0]      oldest_rank;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign key_in = key_i[KW-1:0];
  assign pay_in = PW'(64'(payload_i));

  assign rd_key    = ram_rdata[KW-1:0];
  assign rd_pay    = ram_rdata[PW+KW-1:KW];
  assign rd_charge = ram_rdata[MW-1:PW+KW];

  assign over        = ({1'b0, used_q} + {1'b0, charge_q}) > {1'b0, budget_q};
  assign oldest_rank = IW'(cnt_q - CW'(1));

  // Find oldest valid slot and lowest free slot
  always_comb begin
    oldest    = '0;
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && rank_q[i] == oldest_rank) begin
        oldest = IW'(i);
      end
      if (!valid_q[i]) begin
        free_slot = IW'(i);
      end
    end
  end

  assign ram_raddr = (state_q == StSearch) ? addr_q : slot_q;
  assign ram_wdata = {charge_q, pay_q, key_q};
  assign ram_waddr = free_slot;

  bblru_ram #(
    .WIDTH(MW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    rank_d      = rank_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    hits_d      = hits_q;
    miss_d      = miss_q;
    addr_d      = addr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    slot_d      = slot_q;
    hit_pay_d   = hit_pay_q;
    ev_rdy_d    = 1'b0;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    okey_d      = okey_q;
    opay_d      = opay_q;
    last_d      = last_q;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          addr_d  = '0;
          found_d = 1'b0;
          if (op_i == OpPut && charge_i > budget_q) begin
            state_d = StResolve;
          end else begin
            state_d = StSearch;
          end
        end
      end

      StSearch: begin
        // Issue one read per cycle, compare the previous read
        if (addr_q != IW'(ENTRIES - 1)) begin
          addr_d = addr_q + IW'(1);
        end
        rd_vld_d = 1'b1;
        rd_idx_d = addr_q;
        if (rd_vld_q) begin
          if (valid_q[rd_idx_q] && rd_key == key_q) begin
            found_d   = 1'b1;
            slot_d    = rd_idx_q;
            hit_pay_d = rd_pay;
            state_d   = StResolve;
          end else if (rd_idx_q == IW'(ENTRIES - 1)) begin
            state_d = StResolve;
          end
        end
      end

      StResolve: begin
        if (op_q == OpPut && !found_q && charge_q <= budget_q) begin
          state_d = StCheck;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          last_d      = 1'b1;
          okey_d      = KeyPortW'(key_q);
          opay_d      = '0;
          state_d     = StIdle;
          if (op_q == OpGet) begin
            if (found_q) begin
              hits_d = hits_q + 32'd1;
              kind_d = KindHit;
              opay_d = DataPortW'(64'(hit_pay_q));
              for (int i = 0; i < ENTRIES; i++) begin
                if (IW'(i) != slot_q && valid_q[i] && rank_q[i] < rank_q[slot_q]) begin
                  rank_d[i] = rank_q[i] + IW'(1);
                end
              end
              rank_d[slot_q] = '0;
            end else begin
              miss_d = miss_q + 32'd1;
              kind_d = KindMiss;
            end
          end else if (found_q) begin
            kind_d = KindRefPresent;
          end else begin
            kind_d = KindRefBig;
          end
        end
      end

      StCheck: begin
        if ((over && cnt_q != '0) || cnt_q == CW'(ENTRIES)) begin
          slot_d  = oldest;
          state_d = StEvict;
        end else begin
          state_d = StStore;
        end
      end

      StEvict: begin
        // Wait for the registered RAM read of the oldest slot
        ev_rdy_d = 1'b1;
        if (ev_rdy_q && out_free) begin
          ev_rdy_d        = 1'b0;
          valid_d[slot_q] = 1'b0;
          cnt_d           = cnt_q - CW'(1);
          used_d          = used_q - rd_charge;
          out_valid_d     = 1'b1;
          kind_d          = KindEvicted;
          okey_d          = KeyPortW'(rd_key);
          opay_d          = DataPortW'(64'(rd_pay));
          last_d          = 1'b0;
          state_d         = StCheck;
        end
      end

      StStore: begin
        if (out_free) begin
          ram_we = 1'b1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_q[i]) begin
              rank_d[i] = rank_q[i] + IW'(1);
            end
          end
          rank_d[free_slot]  = '0;
          valid_d[free_slot] = 1'b1;
          cnt_d              = cnt_q + CW'(1);
          used_d             = used_q + charge_q;
          out_valid_d        = 1'b1;
          kind_d             = KindStored;
          okey_d             = KeyPortW'(key_q);
          opay_d             = '0;
          last_d             = 1'b1;
          state_d            = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      budget_q    <= BudgetReset;
      valid_q     <= '0;
      rank_q      <= '{default: '0};
      cnt_q       <= '0;
      used_q      <= '0;
      hits_q      <= '0;
      miss_q      <= '0;
      rd_vld_q    <= 1'b0;
      ev_rdy_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        budget_q <= cfg_data_i;
      end
      valid_q     <= valid_d;
      rank_q      <= rank_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      hits_q      <= hits_d;
      miss_q      <= miss_d;
      rd_vld_q    <= rd_vld_d;
      ev_rdy_q    <= ev_rdy_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= op_i;
      key_q    <= key_in;
      pay_q    <= pay_in;
      charge_q <= charge_i;
    end
    addr_q    <= addr_d;
    rd_idx_q  <= rd_idx_d;
    slot_q    <= slot_d;
    hit_pay_q <= hit_pay_d;
    kind_q    <= kind_d;
    okey_q    <= okey_d;
    opay_q    <= opay_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign key_out_o     = okey_q;
  assign payload_out_o = opay_q;
  assign used_bytes_o  = used_q;
  assign hit_count_o   = hits_q;
  assign miss_count_o  = miss_q;
  assign last_o        = last_q;

  // Entry count tracks the valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CW'($countones(valid_q)))
    else $error("entry count out of step with valid bits");

  // Never more entries than slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ENTRIES))
    else $error("entry count overflow");

  // A stored entry always fits the budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StStore && out_free) |=> used_q <= budget_q)
    else $error("store exceeded byte budget");

  // The final result of a request returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && out_stall_i) && last_d) |=> state_q == StIdle)
    else $error("final result without return to idle");

endmodule

// ===== hdl/bblru_ram.sv =====
module bblru_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
